FILE: hw/rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg: shared definitions for the 3x3 speckle cleanup
// Register indexes, reset values, action codes and the control word that
// travels from the position tracker to the window stage.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int unsigned MaxColumnsDef = 2048;
  localparam int unsigned SampleBitsDef = 32;

  localparam int unsigned ColCfgW  = 12;
  localparam int unsigned RowCfgW  = 16;
  localparam int unsigned FillW    = 32;
  localparam int unsigned DelMinW  = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;

  // one more bit than the row count, the drain runs past the last row
  localparam int unsigned RowW = RowCfgW + 1;

  localparam logic [ColCfgW-1:0]        ColumnsRst = 12'd2048;
  localparam logic [RowCfgW-1:0]        RowsRst    = 16'd1024;
  localparam logic signed [FillW-1:0]   FillRst    = -32'sd2559744;
  localparam logic [DelMinW-1:0]        DelMinRst  = 4'd6;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COLUMNS,
    REG_ROWS,
    REG_FILL,
    REG_DELETE_MIN
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACT_KEEP,
    ACT_ZERO,
    ACT_FILL
  } action_e;

  typedef struct packed {
    logic acts;
    logic take_px;
    logic has_res;
    logic interior;
    logic last;
  } front_ctrl_t;

endpackage

FILE: hw/rtl/rsc_line_ram.sv
// ----------------------------------------------------------------------------
// rsc_line_ram: one line of samples
// Single write port, single read port, registered read data. A read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module rsc_line_ram #(
  parameter int unsigned DEPTH = rsc_pkg::MaxColumnsDef,
  parameter int unsigned WIDTH = rsc_pkg::SampleBitsDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/rsc_front.sv
// ----------------------------------------------------------------------------
// rsc_front: raster position tracker
// Keeps column, row and the count of pixels still owed, decides per beat
// whether it is used, whether it releases a result and where that result
// sits in the frame.
// ----------------------------------------------------------------------------
module rsc_front #(
  parameter int unsigned MAX_COLUMNS = rsc_pkg::MaxColumnsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [rsc_pkg::ColCfgW-1:0]         frame_columns_i,
  input  logic [rsc_pkg::RowCfgW-1:0]         frame_rows_i,
  input  logic                                restart_i,
  input  logic                                accept_i,
  input  logic                                mode_i,
  output rsc_pkg::front_ctrl_t                ctrl_o,
  output logic [$clog2(MAX_COLUMNS)-1:0]      col_o,
  output logic [$clog2(MAX_COLUMNS)-1:0]      pn_o
);

  localparam int unsigned ColW  = $clog2(MAX_COLUMNS);
  localparam int unsigned ColNW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned CmpW  = (ColNW > rsc_pkg::ColCfgW) ? ColNW : rsc_pkg::ColCfgW;
  localparam int unsigned PendW = $clog2(MAX_COLUMNS + 2);
  localparam int unsigned RowW  = rsc_pkg::RowW;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [PendW-1:0] pend_q, pend_d;

  logic [CmpW-1:0]  fc_ext;
  logic [ColNW-1:0] cols_w;
  logic [RowW-1:0]  rows_w;
  logic [RowW-1:0]  pm;
  logic [ColW-1:0]  pn;
  logic             full, col_zero, wrap;

  always_comb begin
    fc_ext = CmpW'(frame_columns_i);
    if (fc_ext == '0) begin
      cols_w = ColNW'(1);
    end else if (fc_ext > CmpW'(MAX_COLUMNS)) begin
      cols_w = ColNW'(MAX_COLUMNS);
    end else begin
      cols_w = ColNW'(fc_ext);
    end
    rows_w = (frame_rows_i == '0) ? RowW'(1) : RowW'(frame_rows_i);

    full     = row_q >= rows_w;
    col_zero = col_q == '0;
    wrap     = (ColNW'(col_q) + ColNW'(1)) >= cols_w;

    ctrl_o.take_px = (mode_i == rsc_pkg::MODE_PIXEL) && !full;
    ctrl_o.acts    = ctrl_o.take_px || (full && pend_q != '0);
    ctrl_o.has_res = !(row_q == '0 || (row_q == RowW'(1) && col_zero));

    pm = col_zero ? row_q - RowW'(2) : row_q - RowW'(1);
    pn = col_zero ? ColW'(cols_w - ColNW'(1)) : col_q - ColW'(1);

    ctrl_o.interior = cols_w >= ColNW'(3) && rows_w >= RowW'(3) &&
                      pm >= RowW'(1) && (pm + RowW'(1)) < rows_w &&
                      pn >= ColW'(1) && (ColNW'(pn) + ColNW'(1)) < cols_w;
    ctrl_o.last     = ctrl_o.has_res && pm == rows_w - RowW'(1) &&
                      ColNW'(pn) == cols_w - ColNW'(1);

    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    if (restart_i) begin
      col_d  = '0;
      row_d  = '0;
      pend_d = '0;
    end else if (accept_i && ctrl_o.acts) begin
      if (wrap) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
      if (ctrl_o.take_px && !ctrl_o.has_res) begin
        pend_d = pend_q + PendW'(1);
      end else if (!ctrl_o.take_px && ctrl_o.has_res) begin
        pend_d = pend_q - PendW'(1);
      end
      if (ctrl_o.last) begin
        col_d  = '0;
        row_d  = '0;
        pend_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end

  assign col_o = col_q;
  assign pn_o  = pn;

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && ctrl_o.acts && ctrl_o.last && !restart_i)
      |=> (col_q == '0 && row_q == '0 && pend_q == '0))
    else $error("frame did not restart after its last pixel");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendW'(cols_w) + PendW'(1))
    else $error("pending pixel count beyond one row plus one");

endmodule

FILE: hw/rtl/rsc_kernel.sv
// ----------------------------------------------------------------------------
// rsc_kernel: 3x3 window and cleanup rule
// Holds the two older window columns, forms the current window from them
// and the fresh column, applies the isolated-pixel and gap-fill rules.
// ----------------------------------------------------------------------------
module rsc_kernel #(
  parameter int unsigned SAMPLE_BITS = rsc_pkg::SampleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  rsc_pkg::front_ctrl_t                ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]       up_i,
  input  logic signed [SAMPLE_BITS-1:0]       mid_i,
  input  logic signed [SAMPLE_BITS-1:0]       x_i,
  input  logic signed [rsc_pkg::FillW-1:0]    fill_i,
  input  logic [rsc_pkg::DelMinW-1:0]         del_min_i,
  output logic signed [SAMPLE_BITS-1:0]       value_o,
  output rsc_pkg::action_e                    action_o
);

  localparam int unsigned CmpW = (SAMPLE_BITS > rsc_pkg::FillW) ? SAMPLE_BITS : rsc_pkg::FillW;
  localparam int unsigned SumW = SAMPLE_BITS + 3;

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;

  samp_t win_q [3][2];

  samp_t                     nb [8];
  samp_t                     centre, mean;
  logic [3:0]                empty_cnt;
  logic                      centre_empty, del, v1_empty;
  logic signed [SumW-1:0]    sum, rnd;

  function automatic logic is_empty(samp_t v, logic signed [rsc_pkg::FillW-1:0] f);
    logic signed [CmpW-1:0] ve;
    logic signed [CmpW-1:0] fe;
    ve = CmpW'(v);
    fe = CmpW'(f);
    return (v == '0) || (ve == fe);
  endfunction

  always_comb begin
    nb[0]  = win_q[0][0];
    nb[1]  = win_q[0][1];
    nb[2]  = up_i;
    nb[3]  = win_q[1][0];
    centre = win_q[1][1];
    nb[4]  = mid_i;
    nb[5]  = win_q[2][0];
    nb[6]  = win_q[2][1];
    nb[7]  = x_i;

    empty_cnt = '0;
    sum       = '0;
    for (int i = 0; i < 8; i++) begin
      if (is_empty(nb[i], fill_i)) begin
        empty_cnt = empty_cnt + 4'd1;
      end
      sum = sum + SumW'(nb[i]);
    end
    rnd  = sum + SumW'(4);
    mean = SAMPLE_BITS'(rnd >>> 3);

    centre_empty = is_empty(centre, fill_i);
    del          = centre_empty ? (del_min_i == '0) : (empty_cnt >= del_min_i);
    v1_empty     = del || centre_empty;

    value_o  = centre;
    action_o = rsc_pkg::ACT_KEEP;
    if (ctrl_i.has_res && ctrl_i.interior) begin
      if (del) begin
        value_o = '0;
        if (centre != '0) begin
          action_o = rsc_pkg::ACT_ZERO;
        end
      end
      if (v1_empty && empty_cnt == '0) begin
        value_o  = mean;
        action_o = rsc_pkg::ACT_FILL;
      end
    end
  end

  // shift left, the old centre moves left as its cleaned value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
    end else if (step_i) begin
      win_q[0][0] <= win_q[0][1];
      win_q[0][1] <= up_i;
      win_q[1][0] <= value_o;
      win_q[1][1] <= mid_i;
      win_q[2][0] <= win_q[2][1];
      win_q[2][1] <= x_i;
    end
  end

endmodule

FILE: hw/rtl/raster_speckle_cleanup_3x3.sv
// Result path: read stage, then output register; the result for a pixel is
//   released by the beat frame_columns + 1 later.
// Throughput: one beat per cycle while the output is taken, set by the window
//   and upper line write-back loop; a waiting result holds off a second beat.
// Reset: control, counters, window and registers to defaults; line memories
//   keep their contents, no clearing pass.
// ----------------------------------------------------------------------------
// raster_speckle_cleanup_3x3: streaming 3x3 speckle cleanup
// Line memories for the cleaned row above and the raw middle row, a read
// stage, a window stage with the cleanup rule and an output register.
// ----------------------------------------------------------------------------
module raster_speckle_cleanup_3x3 #(
  parameter int unsigned MAX_COLUMNS = rsc_pkg::MaxColumnsDef,
  parameter int unsigned SAMPLE_BITS = rsc_pkg::SampleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic signed [SAMPLE_BITS-1:0]     pixel_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     out_value_o,
  output logic [1:0]                        action_o,
  output logic                              frame_last_o,
  input  logic                              cfg_we_i,
  input  logic [rsc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rsc_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int unsigned ColW = $clog2(MAX_COLUMNS);

  logic [rsc_pkg::ColCfgW-1:0]      frame_columns_q;
  logic [rsc_pkg::RowCfgW-1:0]      frame_rows_q;
  logic signed [rsc_pkg::FillW-1:0] fill_q;
  logic [rsc_pkg::DelMinW-1:0]      del_min_q;
  logic                             restart;

  rsc_pkg::front_ctrl_t             ctrl, s0_ctrl_q;
  logic [ColW-1:0]                  col, pn, s0_pn_q;
  logic                             accept, load, fire, out_en;
  logic                             s0_valid_q;
  logic signed [SAMPLE_BITS-1:0]    x, s0_x_q, up_rd, mid_rd, value;
  rsc_pkg::action_e                 action;

  logic                             out_valid_q;
  logic signed [SAMPLE_BITS-1:0]    out_value_q;
  rsc_pkg::action_e                 action_q;
  logic                             frame_last_q;

  assign restart = cfg_we_i && (cfg_index_i == rsc_pkg::REG_COLUMNS ||
                                cfg_index_i == rsc_pkg::REG_ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_columns_q <= rsc_pkg::ColumnsRst;
      frame_rows_q    <= rsc_pkg::RowsRst;
      fill_q          <= rsc_pkg::FillRst;
      del_min_q       <= rsc_pkg::DelMinRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rsc_pkg::REG_COLUMNS:    frame_columns_q <= cfg_wdata_i[rsc_pkg::ColCfgW-1:0];
        rsc_pkg::REG_ROWS:       frame_rows_q    <= cfg_wdata_i[rsc_pkg::RowCfgW-1:0];
        rsc_pkg::REG_FILL:       fill_q          <= cfg_wdata_i[rsc_pkg::FillW-1:0];
        rsc_pkg::REG_DELETE_MIN: del_min_q       <= cfg_wdata_i[rsc_pkg::DelMinW-1:0];
        default: ;
      endcase
    end
  end

  assign out_en     = !out_valid_q || out_ready_i;
  assign fire       = s0_valid_q && out_en;
  assign in_ready_o = !s0_valid_q || fire;
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept && ctrl.acts;
  assign x          = ctrl.take_px ? pixel_value_i : '0;

  rsc_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_columns_i (frame_columns_q),
    .frame_rows_i    (frame_rows_q),
    .restart_i       (restart),
    .accept_i        (accept),
    .mode_i          (mode_i),
    .ctrl_o          (ctrl),
    .col_o           (col),
    .pn_o            (pn)
  );

  rsc_line_ram #(
    .DEPTH(MAX_COLUMNS),
    .WIDTH(SAMPLE_BITS)
  ) u_mid_line (
    .clk_i   (clk_i),
    .we_i    (load),
    .waddr_i (col),
    .wdata_i (x),
    .re_i    (load),
    .raddr_i (col),
    .rdata_o (mid_rd)
  );

  rsc_line_ram #(
    .DEPTH(MAX_COLUMNS),
    .WIDTH(SAMPLE_BITS)
  ) u_up_line (
    .clk_i   (clk_i),
    .we_i    (fire && s0_ctrl_q.has_res),
    .waddr_i (s0_pn_q),
    .wdata_i (value),
    .re_i    (load),
    .raddr_i (col),
    .rdata_o (up_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (load) begin
      s0_valid_q <= 1'b1;
    end else if (fire) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s0_ctrl_q <= ctrl;
      s0_pn_q   <= pn;
      s0_x_q    <= x;
    end
  end

  rsc_kernel #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_kernel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (fire),
    .ctrl_i    (s0_ctrl_q),
    .up_i      (up_rd),
    .mid_i     (mid_rd),
    .x_i       (s0_x_q),
    .fill_i    (fill_q),
    .del_min_i (del_min_q),
    .value_o   (value),
    .action_o  (action)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= s0_ctrl_q.has_res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && s0_ctrl_q.has_res) begin
      out_value_q  <= value;
      action_q     <= action;
      frame_last_q <= s0_ctrl_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign action_o     = action_q;
  assign frame_last_o = frame_last_q;

  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o) |-> (action_o == rsc_pkg::ACT_KEEP))
    else $error("last pixel of the frame was modified");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && !fire) |=> (s0_valid_q && $stable(s0_x_q) && $stable(s0_pn_q)))
    else $error("read stage lost its beat while stalled");

  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s0_valid_q && out_valid_q && !out_ready_i))
    else $error("input held off with room in the pipeline");

endmodule
